[hdl/dhnf_pkg.sv]
// shared types, constants and the reciprocal table of the depth hole neighbour fill core
// no dependencies; imported by every module of the core but dhnf_ram
package dhnf_pkg;

   // pixel and line memory geometry
   localparam int DEPTH_BITS = 8;
   localparam int PIX_W      = DEPTH_BITS + 1;
   localparam int MAX_WIDTH  = 2048;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int ENTRY_W    = 2 * PIX_W;
   localparam int MAX_HEIGHT = 4096;

   // configuration registers
   localparam int CFGW_W      = 12;
   localparam int CFGH_W      = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CFGW_W-1:0] WIDTH_RESET  = CFGW_W'(640);
   localparam logic [CFGH_W-1:0] HEIGHT_RESET = CFGH_W'(480);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);

   // result fields
   localparam int COL_W     = 11;
   localparam int ROW_W     = 12;
   localparam int VAL_W     = 16;
   localparam int RND_W     = 8;
   localparam int FRAC_BITS = 8;
   localparam logic [VAL_W:0] HALF_LSB = (VAL_W + 1)'(1) << (FRAC_BITS - 1);

   // neighbour statistics and reciprocal divide
   localparam int CNT_W      = 4;
   localparam int SUM_W      = DEPTH_BITS + 3;
   localparam int NUM_W      = SUM_W + FRAC_BITS;
   localparam int RCP_SHIFT  = NUM_W + 3;
   localparam int RCP_W      = RCP_SHIFT + 1;
   localparam int PROD_W     = NUM_W + RCP_W;
   localparam int TDATA_IN_W  = ((DEPTH_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_W = COL_W + ROW_W + VAL_W + RND_W;
   localparam int TDATA_OUT_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_OUT
   } state_type;

   // neighbourhood summary held after each window shift
   typedef struct packed {
      logic                  ctr_filled;
      logic [DEPTH_BITS-1:0] ctr_depth;
      logic [CNT_W-1:0]      count;
      logic [NUM_W-1:0]      numer;
   } stats_type;

   // formatted pixel result
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             fixed;
      logic [RND_W-1:0] rounded;
   } result_type;

   // ceil(2^RCP_SHIFT / n) for neighbour counts one to eight
   function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
      logic [63:0] one;
      logic [63:0] r;
      one = 64'd1 << RCP_SHIFT;
      case (n)
         CNT_W'(1): r = one;
         CNT_W'(2): r = (one + 64'd1) / 2;
         CNT_W'(3): r = (one + 64'd2) / 3;
         CNT_W'(4): r = (one + 64'd3) / 4;
         CNT_W'(5): r = (one + 64'd4) / 5;
         CNT_W'(6): r = (one + 64'd5) / 6;
         CNT_W'(7): r = (one + 64'd6) / 7;
         CNT_W'(8): r = (one + 64'd7) / 8;
         default:   r = 64'd0;
      endcase
      return r[RCP_W-1:0];
   endfunction

endpackage

[hdl/depth_hole_neighbor_fill_core.sv]
// top level of the depth hole neighbour fill core: sequencer, counters, line memory
// depends on dhnf_pkg, dhnf_ram, dhnf_window and dhnf_divider
//
// Pixels arrive in raster order, the filled flag on req_tuser and the depth on req_tdata.
// For each interior pixel one result leaves: its column and row, the depth in 8.8 fixed
// point (the centre depth if filled, otherwise the rounded mean of the filled
// 8-neighbours), the rounded integer depth, the fixed flag on rsp_tuser and tlast on the
// last interior pixel of the frame. Border pixels give no result. Both line buffers share
// one memory of 2048 entries, upper and middle row side by side. A pixel that gives a
// result occupies the core through accept, line memory read with window shift, reciprocal
// multiply and output load; a border pixel only through accept and line memory read. A
// finished result waits in the output register while the next pixel is accepted. A write
// to frame_width or frame_height restarts the frame at row 0, column 0. There is no
// clearing pass after reset.
module depth_hole_neighbor_fill_core (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dhnf_pkg::TDATA_IN_W-1:0]   req_tdata,   // pixel_depth
   input  logic                              req_tuser,   // pixel_filled
   // result output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dhnf_pkg::TDATA_OUT_W-1:0]  rsp_tdata,   // center_col, center_row,
                                                          // value_fixed, rounded_depth
   output logic                              rsp_tuser,   // is_fixed
   output logic                              rsp_tlast,   // frame_last
   // configuration
   input  logic                              csr_we,
   input  logic [dhnf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dhnf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dhnf_pkg::*;

   state_type state_ff, state_in;

   logic [CFGW_W-1:0] frame_width_ff,  frame_width_in;
   logic [CFGH_W-1:0] frame_height_ff, frame_height_in;
   logic [CFGW_W-1:0] eff_width;
   logic [CFGH_W-1:0] eff_height;

   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [PIX_W-1:0]  pix_ff;
   logic [ADDR_W-1:0] item_col_ff;
   logic [ROW_W-1:0]  item_row_ff;
   logic              produce_ff, last_ff;
   logic              produce_in, last_in;

   logic              accept;
   logic              ram_re, ram_we, win_shift, mul_start, out_load;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [PIX_W-1:0]  upper_old, middle_old;

   stats_type         stats;
   result_type        result;

   logic              rsp_valid_ff;
   logic [TDATA_OUT_W-1:0] rsp_data_ff;
   logic              rsp_fixed_ff, rsp_last_ff;

   logic [CFGW_W-1:0] col_next;
   logic [CFGH_W-1:0] row_next;

   assign accept = req_tvalid && req_tready;

   // saturated frame geometry
   always_comb begin
      if (frame_width_ff < CFGW_W'(3)) begin
         eff_width = CFGW_W'(3);
      end else if (frame_width_ff > CFGW_W'(MAX_WIDTH)) begin
         eff_width = CFGW_W'(MAX_WIDTH);
      end else begin
         eff_width = frame_width_ff;
      end
      if (frame_height_ff < CFGH_W'(3)) begin
         eff_height = CFGH_W'(3);
      end else if (frame_height_ff > CFGH_W'(MAX_HEIGHT)) begin
         eff_height = CFGH_W'(MAX_HEIGHT);
      end else begin
         eff_height = frame_height_ff;
      end
   end

   // configuration writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata[CFGW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata[CFGH_W-1:0];
            default: ;
         endcase
      end
   end

   // raster position and result qualification of the accepted pixel
   always_comb begin
      col_next   = CFGW_W'(col_ff) + CFGW_W'(1);
      row_next   = CFGH_W'(row_ff) + CFGH_W'(1);
      col_in     = col_ff;
      row_in     = row_ff;
      produce_in = (row_ff >= ROW_W'(2)) && (col_ff >= ADDR_W'(2))
                   && (CFGH_W'(row_ff) < eff_height) && (CFGW_W'(col_ff) < eff_width);
      last_in    = (row_next == eff_height) && (col_next == eff_width);
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_next >= eff_width) begin
            col_in = '0;
            row_in = (row_next >= eff_height) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[ADDR_W-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         produce_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         if (accept) begin
            produce_ff <= produce_in;
         end
      end
   end

   // accepted pixel and its position
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff      <= {req_tuser, req_tdata[DEPTH_BITS-1:0]};
         item_col_ff <= col_ff;
         item_row_ff <= row_ff;
         last_ff     <= last_in;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = produce_ff ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      win_shift  = 1'b0;
      ram_we     = 1'b0;
      mul_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_READ: begin
            win_shift = 1'b1;
            ram_we    = 1'b1;
         end
         ST_MUL:  mul_start = 1'b1;
         ST_OUT:  out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign ram_re = accept;

   // line memory: upper row above middle row in each entry
   dhnf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (item_col_ff),
      .wdata ({middle_old, pix_ff}),
      .re    (ram_re),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   assign upper_old  = ram_rdata[ENTRY_W-1:PIX_W];
   assign middle_old = ram_rdata[PIX_W-1:0];

   // 3x3 window
   dhnf_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (win_shift),
      .col_top (upper_old),
      .col_mid (middle_old),
      .col_bot (pix_ff),
      .stats   (stats)
   );

   // neighbour mean
   dhnf_divider u_divider (
      .clock  (clock),
      .start  (mul_start),
      .stats  (stats),
      .result (result)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff  <= TDATA_OUT_W'({result.rounded, result.value,
                                       ROW_W'(item_row_ff - ROW_W'(1)),
                                       COL_W'(item_col_ff - ADDR_W'(1))});
         rsp_fixed_ff <= result.fixed;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fixed_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/dhnf_ram.sv]
// generic simple dual-port ram with registered read
// no dependencies
module dhnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/dhnf_window.sv]
// 3x3 window registers and neighbourhood statistics
// depends on dhnf_pkg
module dhnf_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic [dhnf_pkg::PIX_W-1:0]  col_top,
   input  logic [dhnf_pkg::PIX_W-1:0]  col_mid,
   input  logic [dhnf_pkg::PIX_W-1:0]  col_bot,
   output dhnf_pkg::stats_type         stats
);
   import dhnf_pkg::*;

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   stats_type        stats_ff;
   stats_type        stats_in;

   // shift left by one column, new column enters on the right
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]     = win_ff[i*3 + 1];
         win_in[i*3 + 1] = win_ff[i*3 + 2];
      end
      win_in[2] = col_top;
      win_in[5] = col_mid;
      win_in[8] = col_bot;
   end

   // count and sum of the filled neighbours of the new centre
   always_comb begin
      logic [CNT_W-1:0] n;
      logic [SUM_W-1:0] s;
      n = '0;
      s = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && win_in[k][DEPTH_BITS]) begin
            n = n + CNT_W'(1);
            s = s + SUM_W'(win_in[k][DEPTH_BITS-1:0]);
         end
      end
      stats_in.ctr_filled = win_in[4][DEPTH_BITS];
      stats_in.ctr_depth  = win_in[4][DEPTH_BITS-1:0];
      stats_in.count      = n;
      stats_in.numer      = {s, FRAC_BITS'(0)} + NUM_W'(n >> 1);
   end

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (shift) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // statistics register
   always_ff @(posedge clock) begin
      if (shift) begin
         stats_ff <= stats_in;
      end
   end

   assign stats = stats_ff;

endmodule

[hdl/dhnf_divider.sv]
// reciprocal multiply for the neighbour mean and result formatting
// depends on dhnf_pkg
module dhnf_divider (
   input  logic                clock,
   input  logic                start,
   input  dhnf_pkg::stats_type stats,
   output dhnf_pkg::result_type result
);
   import dhnf_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [VAL_W-1:0]  quot;
   logic [VAL_W:0]    round_sum;

   // numerator times ceil(2^k / n) is exact for every count one to eight
   assign prod_in = PROD_W'(stats.numer) * PROD_W'(recip_of(stats.count));

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   assign quot = prod_ff[RCP_SHIFT +: VAL_W];

   // filled centre keeps its depth, hole takes the mean, lone hole stays open
   always_comb begin
      if (stats.ctr_filled) begin
         result.value = VAL_W'({stats.ctr_depth, FRAC_BITS'(0)});
         result.fixed = 1'b1;
      end else if (stats.count != '0) begin
         result.value = quot;
         result.fixed = 1'b1;
      end else begin
         result.value = '0;
         result.fixed = 1'b0;
      end
      round_sum      = {1'b0, result.value} + HALF_LSB;
      result.rounded = round_sum[FRAC_BITS +: RND_W];
   end

endmodule

[test/tb_depth_hole_neighbor_fill_core.sv]
// self-checking testbench for depth_hole_neighbor_fill_core: raster pixel frames in,
// per-pixel fill results checked against an in-bench line store and window predictor
// depends on dhnf_pkg and depth_hole_neighbor_fill_core
module tb_depth_hole_neighbor_fill_core;
   import dhnf_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_SETTLE  = 8;
   localparam int RANDOM_PIXELS = 750;
   localparam int WIDE_PIXELS   = 120;
   localparam int TALL_PIXELS   = 150;
   // filled map of the directed 4x4 frame, bit i is pixel i in raster order
   localparam logic [15:0] HOLE_PATTERN = 16'hF888;

   // one expected or observed result transfer
   typedef struct {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [VAL_W-1:0] value;
      logic             fixed;
      logic [RND_W-1:0] rounded;
      logic             last;
   } fill_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_IN_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   depth_hole_neighbor_fill_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state: registers, both line stores, window and raster position
   logic [CFGW_W-1:0] cfg_width = WIDTH_RESET;
   logic [CFGH_W-1:0] cfg_height = HEIGHT_RESET;
   logic [PIX_W-1:0]  upper_line [0:MAX_WIDTH-1];
   logic [PIX_W-1:0]  middle_line [0:MAX_WIDTH-1];
   logic [PIX_W-1:0]  win [0:2][0:2];
   int unsigned       next_col = 0;
   int unsigned       next_row = 0;

   fill_type pending_fills[$];
   int    mismatches = 0;
   int    pixels_sent = 0;
   int    fills_seen = 0;
   int    frames_started = 0;
   int    cycle_count = 0;
   int    rsp_hold = 0;
   bit    steady_sender = 1'b0;
   bit    steady_receiver = 1'b0;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_fills.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_gap(input bit steady);
      if (steady)
         return 0;
      return $urandom_range(0, 7);
   endfunction

   // register values saturated as the core uses them
   function automatic int unsigned eff_width();
      int unsigned w;
      w = cfg_width;
      if (w < 3)
         w = 3;
      if (w > MAX_WIDTH)
         w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = cfg_height;
      if (h < 3)
         h = 3;
      if (h > MAX_HEIGHT)
         h = MAX_HEIGHT;
      return h;
   endfunction

   // shift the window, update the line stores and queue the fill for the centre pixel
   task automatic predict_fill(input logic filled, input logic [DEPTH_BITS-1:0] depth);
      int unsigned w, h, c, r, n, s, val;
      int i, j;
      logic [PIX_W-1:0] pix, ctr;
      fill_type want;
      w = eff_width();
      h = eff_height();
      c = next_col;
      r = next_row;
      pix = {filled, depth};
      for (i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = pix;
      upper_line[c] = middle_line[c];
      middle_line[c] = pix;
      if (r >= 2 && c >= 2) begin
         ctr = win[1][1];
         val = 0;
         want.fixed = 1'b0;
         if (ctr[PIX_W-1]) begin
            val = 32'(ctr[DEPTH_BITS-1:0]) << FRAC_BITS;
            want.fixed = 1'b1;
         end else begin
            // mean of the filled neighbours, rounded to nearest
            n = 0;
            s = 0;
            for (i = 0; i < 3; i++) begin
               for (j = 0; j < 3; j++) begin
                  if (!(i == 1 && j == 1) && win[i][j][PIX_W-1]) begin
                     n++;
                     s += win[i][j][DEPTH_BITS-1:0];
                  end
               end
            end
            if (n != 0) begin
               val = ((s << FRAC_BITS) + n / 2) / n;
               want.fixed = 1'b1;
            end
         end
         want.col = COL_W'(c - 1);
         want.row = ROW_W'(r - 1);
         want.value = VAL_W'(val);
         want.rounded = want.fixed ? RND_W'((val + (1 << (FRAC_BITS - 1))) >> FRAC_BITS) : '0;
         want.last = (r + 1 == h) && (c + 1 == w);
         pending_fills.push_back(want);
      end
      // raster position, wrapping at the end of row and frame
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   // one pixel transfer, after a random gap unless the sender is steady
   task automatic send_pixel(input logic filled, input logic [DEPTH_BITS-1:0] depth);
      int gap;
      gap = draw_gap(steady_sender);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= TDATA_IN_W'(depth);
      req_tuser <= filled;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (next_col == 0 && next_row == 0)
         frames_started++;
      predict_fill(filled, depth);
      pixels_sent++;
   endtask

   // stop sending until every queued result has left, then let the core settle
   task automatic hold_until_drained(input int settle);
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_fills.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // register write, only with the core idle; any write restarts the frame
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      hold_until_drained(DRAIN_SETTLE);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_FRAME_WIDTH)
         cfg_width = value[CFGW_W-1:0];
      else
         cfg_height = value[CFGH_W-1:0];
      next_col = 0;
      next_row = 0;
   endtask

   // pixels with random depth, filled at the given percentage, the odd mid-frame pause
   task automatic send_pixels(input int count, input int density);
      int k;
      logic filled;
      logic [DEPTH_BITS-1:0] depth;
      for (k = 0; k < count; k++) begin
         filled = $urandom_range(0, 99) < density;
         case ($urandom_range(0, 7))
            0: depth = '0;
            1: depth = '1;
            default: depth = DEPTH_BITS'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 199) == 0)
            hold_until_drained(0);
         send_pixel(filled, depth);
      end
   endtask

   // directed: zero, three and five neighbours, ignored hole depths, saturated registers
   task automatic test_directed_holes();
      int i;
      logic filled;
      logic [DEPTH_BITS-1:0] depth;
      write_register(REG_FRAME_WIDTH, CSR_DATA_W'(4));
      write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(4));
      for (i = 0; i < 16; i++) begin
         filled = HOLE_PATTERN[i];
         case (i % 4)
            0: depth = 8'd255;
            1: depth = 8'd0;
            2: depth = 8'd1;
            default: depth = 8'd254;
         endcase
         // hole depth carries junk that must not leak into the mean
         if (!filled)
            depth = ~depth;
         send_pixel(filled, depth);
         if (i == 11)
            hold_until_drained(0);
      end
      // width and height below range behave as 3, centre filled at full depth
      write_register(REG_FRAME_WIDTH, CSR_DATA_W'(0));
      write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(2));
      for (i = 0; i < 9; i++)
         send_pixel((i == 4) || (i % 2 == 0), (i == 4) ? 8'd255 : 8'(i * 31));
   endtask

   // widest frame: width register above range, start of the top row gives no result
   task automatic test_widest_frame();
      write_register(REG_FRAME_WIDTH, '1);
      write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(3));
      send_pixels(WIDE_PIXELS, 50);
   endtask

   // tallest frame: height register above range, first rows of a narrow frame
   task automatic test_tallest_frame();
      write_register(REG_FRAME_WIDTH, CSR_DATA_W'(3));
      write_register(REG_FRAME_HEIGHT, '1);
      steady_receiver = 1'b1;
      send_pixels(TALL_PIXELS, 70);
      steady_receiver = 1'b0;
   endtask

   // small random frames: varied densities, back-to-back frames, restarts mid-frame
   task automatic test_random_frames();
      int sent_here, full, count, density;
      bit keep_config;
      sent_here = 0;
      keep_config = 1'b0;
      while (sent_here < RANDOM_PIXELS) begin
         if (!keep_config) begin
            if ($urandom_range(0, 1)) begin
               write_register(REG_FRAME_WIDTH, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 2) : $urandom_range(3, 14)));
               write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 2) : $urandom_range(3, 10)));
            end else begin
               write_register(REG_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(3, 10)));
               write_register(REG_FRAME_WIDTH, CSR_DATA_W'($urandom_range(3, 14)));
            end
         end
         case ($urandom_range(0, 4))
            0: density = 0;
            1: density = 15;
            2: density = 50;
            3: density = 85;
            default: density = 100;
         endcase
         steady_sender = ($urandom_range(0, 3) == 0);
         steady_receiver = ($urandom_range(0, 3) == 0);
         full = eff_width() * eff_height();
         count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full - 1) : full;
         send_pixels(count, density);
         sent_here += count;
         keep_config = (count == full) && ($urandom_range(0, 2) == 0);
      end
      steady_sender = 1'b0;
      steady_receiver = 1'b0;
   endtask

   // result side ready, with a random stall after each transfer unless the receiver is steady
   always @(posedge clock) begin : drive_rsp_ready
      if (rsp_tvalid && rsp_tready)
         rsp_hold = draw_gap(steady_receiver);
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         // beyond this only counted, to keep the log readable
         if (mismatches <= 200)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // compare each result transfer with the oldest expected fill
   always @(posedge clock) begin : check_fills
      fill_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         fills_seen++;
         if (pending_fills.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got col %0d row %0d value %0d",
                     $time, rsp_tdata[COL_W-1:0], rsp_tdata[COL_W +: ROW_W],
                     rsp_tdata[COL_W+ROW_W +: VAL_W]);
         end else begin
            want = pending_fills.pop_front();
            check_field("center_col", want.col, rsp_tdata[COL_W-1:0]);
            check_field("center_row", want.row, rsp_tdata[COL_W +: ROW_W]);
            check_field("value_fixed", want.value, rsp_tdata[COL_W+ROW_W +: VAL_W]);
            check_field("rounded_depth", want.rounded,
                        rsp_tdata[COL_W+ROW_W+VAL_W +: RND_W]);
            check_field("is_fixed", want.fixed, rsp_tuser);
            check_field("frame_last", want.last, rsp_tlast);
         end
      end
   end

   // reset, tests in turn, drain and verdict
   initial begin
      for (int a = 0; a < MAX_WIDTH; a++) begin
         upper_line[a] = '0;
         middle_line[a] = '0;
      end
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            win[a][b] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_holes();
      test_widest_frame();
      test_tallest_frame();
      test_random_frames();
      hold_until_drained(DRAIN_SETTLE);
      $display("sent %0d pixels over %0d frames, widths 3 to %0d and heights 3 to %0d",
               pixels_sent, frames_started, MAX_WIDTH, MAX_HEIGHT);
      $display("checked %0d fill results, %0d mismatches", fills_seen, mismatches);
      if (mismatches == 0 && pending_fills.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
